// ===== hw/rtl/ssm_pkg.sv =====
package ssm_pkg;

   // Field widths
   localparam int PULSE_W    = 12;
   localparam int RANGE_W    = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Datapath widths: scaled offset, its magnitude, span magnitude, mix sums
   localparam int DIFF_W = PULSE_W + 1;
   localparam int PROD_W = 23;
   localparam int NUM_W  = 22;
   localparam int DEN_W  = PULSE_W;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int MIX_W  = 25;
   localparam int BAND_W = PULSE_W + 2;

   // Mapping constants: roll spans 1000 steps, centered on zero
   localparam logic signed [10:0] SCALE       = 11'sd1000;
   localparam int                 TURN_OFFSET = 500;

   // Register reset values
   localparam logic [PULSE_W-1:0] MIN_RESET      = 12'd1000;
   localparam logic [PULSE_W-1:0] MAX_RESET      = 12'd2000;
   localparam logic [PULSE_W-1:0] IDLE_RESET     = 12'd1500;
   localparam logic [RANGE_W-1:0] DEADZONE_RESET = 11'd100;
   localparam logic [RANGE_W-1:0] FLUTTER_RESET  = 11'd10;
   localparam logic [PULSE_W-1:0] ARM_RESET      = 12'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN      = 3'd0,
      CSR_MAX      = 3'd1,
      CSR_IDLE     = 3'd2,
      CSR_DEADZONE = 3'd3,
      CSR_FLUTTER  = 3'd4,
      CSR_ARM      = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LOAD,
      ST_DIVIDE,
      ST_MIX,
      ST_LIMIT,
      ST_SETTLE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hw/rtl/ssm_req_if.sv =====
interface ssm_req_if import ssm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] roll_pulse;
   logic [PULSE_W-1:0] pitch_pulse;

   modport source (output valid, output roll_pulse, output pitch_pulse, input ready);
   modport sink (input valid, input roll_pulse, input pitch_pulse, output ready);
endinterface

// ===== hw/rtl/ssm_rsp_if.sv =====
interface ssm_rsp_if import ssm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] left_pulse;
   logic [PULSE_W-1:0] right_pulse;
   logic               left_updated;
   logic               right_updated;

   modport source (output valid, output left_pulse, output right_pulse,
                   output left_updated, output right_updated, input ready);
   modport sink (input valid, input left_pulse, input right_pulse,
                 input left_updated, input right_updated, output ready);
endinterface

// ===== hw/rtl/skid_steer_mixer_with_deadband.sv =====
// Latency: a request passes the scale, load, divide, mix, limit, settle and
// result states; the restoring divider that maps roll onto the turn term sets
// most of it. Throughput: a single request is in flight and req ready is low
// until its response leaves.
// Reset: synchronous, active high; configuration registers return to their
// defaults and both held pulses load the arm pulse default.
module skid_steer_mixer_with_deadband import ssm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ssm_req_if.sink               req_if,
   ssm_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [PULSE_W-1:0] min_ff, max_ff, idle_ff;
   logic [RANGE_W-1:0] deadzone_ff, flutter_ff;
   logic [PULSE_W-1:0] left_held_ff, right_held_ff;
   logic [PULSE_W-1:0] left_held_in, right_held_in;
   logic               left_upd_ff, right_upd_ff;
   logic               left_upd_in, right_upd_in;

   logic [PULSE_W-1:0] roll_ff, pitch_ff;
   logic [NUM_W-1:0]   num_mag_ff;
   logic [DEN_W-1:0]   den_mag_ff;
   logic               quo_neg_ff, span_zero_ff;
   logic signed [MIX_W-1:0] left_raw_ff, right_raw_ff;
   logic [PULSE_W-1:0] left_lim_ff, right_lim_ff;

   logic signed [DIFF_W-1:0] diff_c, span_c;
   logic signed [PROD_W-1:0] prod_c;
   logic signed [MIX_W-1:0]  quo_s, turn_c, pitch_s;

   logic               div_start;
   logic [NUM_W-1:0]   div_quo;
   div_status_type     div_status;
   logic               req_accept;
   logic               rsp_accept;

   // Clamp to [min, max], then snap the idle band to idle
   function automatic logic [PULSE_W-1:0] limit_pulse(
      input logic signed [MIX_W-1:0] v,
      input logic [PULSE_W-1:0]      lo,
      input logic [PULSE_W-1:0]      hi,
      input logic [PULSE_W-1:0]      idle,
      input logic [RANGE_W-1:0]      dz
   );
      logic [PULSE_W-1:0]       c;
      logic signed [BAND_W-1:0] c_s, band_lo, band_hi;
      if (v < $signed({{(MIX_W-PULSE_W){1'b0}}, lo})) begin
         c = lo;
      end else if (v > $signed({{(MIX_W-PULSE_W){1'b0}}, hi})) begin
         c = hi;
      end else begin
         c = v[PULSE_W-1:0];
      end
      c_s     = $signed({2'b00, c});
      band_lo = $signed({2'b00, idle}) - $signed({3'b000, dz});
      band_hi = $signed({2'b00, idle}) + $signed({3'b000, dz});
      return (c_s >= band_lo && c_s <= band_hi) ? idle : c;
   endfunction

   // True when the held pulse lies outside new value +- flutter
   function automatic logic flutter_hit(
      input logic [PULSE_W-1:0] cur,
      input logic [PULSE_W-1:0] v,
      input logic [RANGE_W-1:0] fr
   );
      logic signed [BAND_W-1:0] cur_s, lo, hi;
      cur_s = $signed({2'b00, cur});
      lo    = $signed({2'b00, v}) - $signed({3'b000, fr});
      hi    = $signed({2'b00, v}) + $signed({3'b000, fr});
      return cur_s < lo || cur_s > hi;
   endfunction

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_accept = rsp_if.valid && rsp_if.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_status.done) state_in = ST_MIX;
         ST_MIX:    state_in = ST_LIMIT;
         ST_LIMIT:  state_in = ST_SETTLE;
         ST_SETTLE: state_in = ST_RESULT;
         ST_RESULT: if (rsp_accept) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_if.ready = 1'b1;
         ST_LOAD:   div_start    = 1'b1;
         ST_RESULT: rsp_if.valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= MIN_RESET;
         max_ff      <= MAX_RESET;
         idle_ff     <= IDLE_RESET;
         deadzone_ff <= DEADZONE_RESET;
         flutter_ff  <= FLUTTER_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_idx))
            CSR_MIN:      min_ff      <= csr_wdata[PULSE_W-1:0];
            CSR_MAX:      max_ff      <= csr_wdata[PULSE_W-1:0];
            CSR_IDLE:     idle_ff     <= csr_wdata[PULSE_W-1:0];
            CSR_DEADZONE: deadzone_ff <= csr_wdata[RANGE_W-1:0];
            CSR_FLUTTER:  flutter_ff  <= csr_wdata[RANGE_W-1:0];
            // Arm value only reloads the held pulses below
            CSR_ARM: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Scale roll offset and split the signed division into magnitudes
   always_comb begin
      diff_c = $signed({1'b0, roll_ff}) - $signed({1'b0, min_ff});
      span_c = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
      prod_c = PROD_W'(diff_c) * PROD_W'(SCALE);
   end

   // Turn term: signed quotient minus half the scale, zero for equal limits
   always_comb begin
      quo_s   = $signed({{(MIX_W-NUM_W){1'b0}}, div_quo});
      pitch_s = $signed({{(MIX_W-PULSE_W){1'b0}}, pitch_ff});
      turn_c  = span_zero_ff ? '0
                : ((quo_neg_ff ? -quo_s : quo_s) - MIX_W'(TURN_OFFSET));
   end

   // Request pipeline registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         roll_ff  <= req_if.roll_pulse;
         pitch_ff <= req_if.pitch_pulse;
      end
      if (state_ff == ST_SCALE) begin
         num_mag_ff   <= prod_c[PROD_W-1] ? NUM_W'(-prod_c) : NUM_W'(prod_c);
         den_mag_ff   <= span_c[DIFF_W-1] ? DEN_W'(-span_c) : DEN_W'(span_c);
         quo_neg_ff   <= prod_c[PROD_W-1] ^ span_c[DIFF_W-1];
         span_zero_ff <= span_c == '0;
      end
      if (state_ff == ST_MIX) begin
         if (pitch_ff >= idle_ff) begin
            left_raw_ff  <= pitch_s + turn_c;
            right_raw_ff <= pitch_s - turn_c;
         end else begin
            left_raw_ff  <= pitch_s - turn_c;
            right_raw_ff <= pitch_s + turn_c;
         end
      end
      if (state_ff == ST_LIMIT) begin
         left_lim_ff  <= limit_pulse(left_raw_ff, min_ff, max_ff, idle_ff, deadzone_ff);
         right_lim_ff <= limit_pulse(right_raw_ff, min_ff, max_ff, idle_ff, deadzone_ff);
      end
   end

   // Flutter filter on each side's held pulse
   always_comb begin
      left_upd_in   = flutter_hit(left_held_ff, left_lim_ff, flutter_ff);
      right_upd_in  = flutter_hit(right_held_ff, right_lim_ff, flutter_ff);
      left_held_in  = left_upd_in ? left_lim_ff : left_held_ff;
      right_held_in = right_upd_in ? right_lim_ff : right_held_ff;
   end

   // Hold pulses; an arm write reloads both
   always_ff @(posedge clock) begin
      if (reset) begin
         left_held_ff  <= ARM_RESET;
         right_held_ff <= ARM_RESET;
      end else if (csr_we && csr_index_type'(csr_idx) == CSR_ARM) begin
         left_held_ff  <= csr_wdata[PULSE_W-1:0];
         right_held_ff <= csr_wdata[PULSE_W-1:0];
      end else if (state_ff == ST_SETTLE) begin
         left_held_ff  <= left_held_in;
         right_held_ff <= right_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SETTLE) begin
         left_upd_ff  <= left_upd_in;
         right_upd_ff <= right_upd_in;
      end
   end

   ssm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag_ff),
      .divisor  (den_mag_ff),
      .quotient (div_quo),
      .status   (div_status)
   );

   // Drive the response from the held pulses
   assign rsp_if.left_pulse    = left_held_ff;
   assign rsp_if.right_pulse   = right_held_ff;
   assign rsp_if.left_updated  = left_upd_ff;
   assign rsp_if.right_updated = right_upd_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_if.ready)
      else $error("ready stayed high after a request was taken");

   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIVIDE)
      else $error("divider running outside the divide state");

   a_left_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETTLE |=>
         rsp_if.left_updated == (left_held_ff != $past(left_held_ff)))
      else $error("left update flag disagrees with held pulse change");

   a_right_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETTLE |=>
         rsp_if.right_updated == (right_held_ff != $past(right_held_ff)))
      else $error("right update flag disagrees with held pulse change");

endmodule

// ===== hw/rtl/ssm_div.sv =====
module ssm_div import ssm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output div_status_type   status
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_diff;
   logic             fits;
   logic             last;

   // Restoring step: shift in one dividend bit, subtract when it fits
   always_comb begin
      trial      = {rem_ff, quo_ff[NUM_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      fits       = trial >= {1'b0, den_ff};
      last       = cnt_ff == CNT_W'(NUM_W - 1);
      rem_in     = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in     = {quo_ff[NUM_W-2:0], fits};
      cnt_in     = cnt_ff + 1'b1;
      busy_in    = busy_ff && !last;
      done_in    = busy_ff && last;
   end

   // Control: load on start, count one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // Datapath: partial remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
